>>> hw/rtl/hcsa_pkg.sv
// shared types and constants of the hot/cold slot allocator
package hcsa_pkg;

  localparam int Slots   = 32;
  localparam int Handles = 1024;

  localparam logic [1:0] OP_ALLOC   = 2'd0;
  localparam logic [1:0] OP_RELEASE = 2'd1;
  localparam logic [1:0] OP_ACCESS  = 2'd2;
  localparam logic [1:0] OP_INVALID = 2'd3;

  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_NO_SLOT   = 2'd1;
  localparam logic [1:0] ST_EXHAUSTED = 2'd2;
  localparam logic [1:0] ST_BAD       = 2'd3;

  localparam logic [1:0] TIER_COLD = 2'd0;
  localparam logic [1:0] TIER_WARM = 2'd1;
  localparam logic [1:0] TIER_HOT  = 2'd2;

  localparam logic       KIND_ANSWER = 1'b0;
  localparam logic       KIND_SWAP   = 1'b1;

  localparam logic [0:0] REG_EPOCH_LENGTH = 1'd0;
  localparam logic [0:0] REG_HOT_PERCENT  = 1'd1;

  localparam int CfgWidth = 16;
  localparam int WarmExtra = 30;

  typedef struct packed {
    logic [1:0] operation;
    logic [9:0] handle_in;
  } req_t;

  typedef struct packed {
    logic       kind;
    logic [1:0] status;
    logic [9:0] handle_out;
    logic [4:0] slot;
    logic [4:0] partner_slot;
    logic [1:0] zone;
    logic       last;
  } rsp_t;

endpackage

>>> hw/rtl/hcsa_ram.sv
// generic single-port write, single-port read ram with registered read
module hcsa_ram #(
  parameter int Width = 8,
  parameter int Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem [Depth];

  // write port and registered read port
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    rdata_o <= mem[raddr_i];
  end

endmodule

>>> hw/rtl/hot_cold_slot_allocator.sv
// top level of the hot/cold slot allocator
// The handle table lives in a synchronous ram (one word per handle: slot and
// valid bit); slot records (owner, use, zone, hit count) and the free stack
// live in small register files. Allocate, release and an access that ends no
// epoch go through handle-table read, check and update, and answer; a held
// answer holds the next request in its check step. An epoch-ending access
// ranks the n used slots by one selection pass over the slot file per rank,
// then, for each misplaced rank, emits a swap with its command and then one
// handle-table patch per swapped slot, and skips each rank already in place;
// then it zones the ranks one per cycle and answers. Swap commands wait while
// the result register is held. After reset the handle table is cleared entry
// by entry, during which no request is accepted. The result register lets
// the block finish the step that produced a result while the result waits to
// be taken.
module hot_cold_slot_allocator (
  input  logic                       clk_i,
  input  logic                       rst_ni,
  input  logic                       in_valid_i,
  output logic                       in_stall_o,
  input  hcsa_pkg::req_t             in_data_i,
  output logic                       out_valid_o,
  input  logic                       out_stall_i,
  output hcsa_pkg::rsp_t             out_data_o,
  input  logic                       cfg_we_i,
  input  logic                       cfg_index_i,
  input  logic [hcsa_pkg::CfgWidth-1:0] cfg_data_i
);
  import hcsa_pkg::*;

  localparam int SLOTS   = Slots;
  localparam int HANDLES = Handles;
  localparam int SW = $clog2(SLOTS);
  localparam int HW = $clog2(HANDLES);
  localparam int NW = $clog2(SLOTS + 1);
  localparam int HCW = $clog2(HANDLES + 1);

  localparam logic [3:0] S_CLEAR = 4'd0, S_IDLE = 4'd1, S_READ = 4'd2,
                         S_EXEC = 4'd3, S_SORT = 4'd4, S_PERM = 4'd5,
                         S_ZONE = 4'd6, S_FIN = 4'd7, S_OUT = 4'd8,
                         S_PATCH = 4'd9;

  // floor(x/100) by reciprocal multiply, exact for x below 2^14
  function automatic logic [NW+7:0] div100(logic [NW+7:0] x);
    logic [NW+21:0] p;
    p = (NW+22)'(x) * (NW+22)'(5243);
    return (NW+8)'(p >> 19);
  endfunction

  // configuration
  logic [15:0] epoch_len_q;
  logic [6:0]  hot_pct_q;
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      epoch_len_q <= 16'd1024;
      hot_pct_q   <= 7'd20;
    end else if (cfg_we_i) begin
      if (cfg_index_i == REG_EPOCH_LENGTH) epoch_len_q <= cfg_data_i;
      else hot_pct_q <= cfg_data_i[6:0];
    end
  end

  // handle table ram: {valid, slot}
  logic          hm_we;
  logic [HW-1:0] hm_waddr, hm_raddr;
  logic [SW:0]   hm_wdata, hm_rdata;
  hcsa_ram #(.Width(SW + 1), .Depth(HANDLES)) u_hmap (
    .clk_i, .we_i(hm_we), .waddr_i(hm_waddr), .wdata_i(hm_wdata),
    .raddr_i(hm_raddr), .rdata_o(hm_rdata)
  );

  // slot records
  logic [HW-1:0] owner_q [SLOTS];
  logic          used_q  [SLOTS];
  logic [1:0]    zone_q  [SLOTS];
  logic [15:0]   hits_q  [SLOTS];
  logic [SW-1:0] free_q  [SLOTS];
  logic [SW-1:0] rank_q  [SLOTS];
  logic [NW-1:0] free_depth_q;
  logic [HCW-1:0] next_handle_q;
  logic [15:0]   epoch_q;

  logic [3:0]    state_q;
  req_t          req_q;
  logic [SW-1:0] slot_q;
  logic          out_valid_q;
  rsp_t          out_q;
  logic [HW:0]   clr_q;
  // sort / permute bookkeeping
  logic [NW-1:0] n_q, t_q;
  logic [SW-1:0] scan_q, best_q;
  logic          best_ok_q;
  logic [SLOTS-1:0] taken_q;
  logic [NW-1:0] n_hot_q, n_warm_q;
  logic [SW-1:0] pa_q, pb_q;

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

  wire out_free = !out_valid_q || !out_stall_i;

  // zone thresholds: widths small, one multiply and a constant divide per threshold
  logic [NW+7:0] prod_hot, prod_warm, hot_div, warm_div;
  assign prod_hot  = (NW+8)'(n_q) * (NW+8)'(hot_pct_q);
  assign prod_warm = (NW+8)'(n_q) * (NW+8)'({1'b0, hot_pct_q} + 8'(WarmExtra));
  assign hot_div   = div100(prod_hot);
  assign warm_div  = div100(prod_warm);

  logic [SW-1:0] cur_slot;
  assign cur_slot = hm_rdata[SW-1:0];

  always_comb begin
    hm_raddr = req_q.handle_in[HW-1:0];
    if (state_q == S_IDLE) hm_raddr = in_data_i.handle_in[HW-1:0];
  end

  // main sequencer
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
      clr_q <= '0;
      out_valid_q <= 1'b0;
      out_q <= '0;
      req_q <= '0;
      slot_q <= '0;
      n_q <= '0;
      t_q <= '0;
      scan_q <= '0;
      best_q <= '0;
      best_ok_q <= 1'b0;
      taken_q <= '0;
      n_hot_q <= '0;
      n_warm_q <= '0;
      pa_q <= '0;
      pb_q <= '0;
      free_depth_q <= NW'(SLOTS);
      next_handle_q <= '0;
      epoch_q <= '0;
      for (int i = 0; i < SLOTS; i++) begin
        used_q[i] <= 1'b0;
        zone_q[i] <= TIER_COLD;
        hits_q[i] <= '0;
        owner_q[i] <= '0;
        rank_q[i] <= '0;
        free_q[i] <= SW'(SLOTS - 1 - i);
      end
    end else begin
      rsp_t rsp;
      logic emit;
      rsp = '0;
      emit = 1'b0;
      case (state_q)
        S_CLEAR: begin
          clr_q <= clr_q + 1'b1;
          if (clr_q == (HW+1)'(HANDLES - 1)) state_q <= S_IDLE;
        end
        S_IDLE: begin
          if (in_valid_i) begin
            req_q <= in_data_i;
            state_q <= S_READ;
          end
        end
        S_READ: state_q <= S_EXEC;
        S_EXEC: if (out_free) begin
          rsp.last = 1'b1;
          emit = 1'b1;
          if (req_q.operation == OP_ALLOC) begin
            state_q <= S_IDLE;
            if (free_depth_q == '0) rsp.status = ST_NO_SLOT;
            else if (next_handle_q == HCW'(HANDLES)) rsp.status = ST_EXHAUSTED;
            else begin
              logic [SW-1:0] s;
              s = free_q[free_depth_q[SW-1:0] - 1'b1];
              free_depth_q <= free_depth_q - 1'b1;
              next_handle_q <= next_handle_q + 1'b1;
              owner_q[s] <= next_handle_q[HW-1:0];
              used_q[s] <= 1'b1;
              zone_q[s] <= TIER_COLD;
              hits_q[s] <= '0;
              rsp.handle_out = 10'(next_handle_q[HW-1:0]);
              rsp.slot = 5'(s);
            end
          end else if (req_q.operation == OP_INVALID ||
                       HCW'(req_q.handle_in) >= next_handle_q || !hm_rdata[SW]) begin
            state_q <= S_IDLE;
            rsp.status = ST_BAD;
            rsp.handle_out = req_q.handle_in;
          end else if (req_q.operation == OP_RELEASE) begin
            state_q <= S_IDLE;
            used_q[cur_slot] <= 1'b0;
            owner_q[cur_slot] <= '0;
            free_q[free_depth_q[SW-1:0]] <= cur_slot;
            free_depth_q <= free_depth_q + 1'b1;
            rsp.handle_out = req_q.handle_in;
            rsp.slot = 5'(cur_slot);
            rsp.zone = zone_q[cur_slot];
          end else begin
            if (hits_q[cur_slot] != 16'hFFFF) hits_q[cur_slot] <= hits_q[cur_slot] + 1'b1;
            if (epoch_q + 1'b1 >= epoch_len_q) begin
              emit = 1'b0;
              epoch_q <= '0;
              slot_q <= cur_slot;
              n_q <= '0;
              t_q <= '0;
              scan_q <= '0;
              best_ok_q <= 1'b0;
              taken_q <= '0;
              state_q <= S_SORT;
            end else begin
              epoch_q <= epoch_q + 1'b1;
              rsp.handle_out = req_q.handle_in;
              rsp.slot = 5'(cur_slot);
              rsp.zone = zone_q[cur_slot];
              state_q <= S_IDLE;
            end
          end
        end
        // selection sort: one candidate slot per cycle
        S_SORT: begin
          logic better;
          better = used_q[scan_q] && !taken_q[scan_q] &&
                   (!best_ok_q || hits_q[scan_q] > hits_q[best_q]);
          if (scan_q == SW'(SLOTS - 1)) begin
            scan_q <= '0;
            best_ok_q <= 1'b0;
            if (better || best_ok_q) begin
              logic [SW-1:0] b;
              b = better ? scan_q : best_q;
              rank_q[n_q[SW-1:0]] <= b;
              taken_q[b] <= 1'b1;
              n_q <= n_q + 1'b1;
            end else begin
              state_q <= S_PERM;
            end
          end else begin
            scan_q <= scan_q + 1'b1;
            if (better) begin
              best_q <= scan_q;
              best_ok_q <= 1'b1;
            end
          end
        end
        // one swap per rank out of place
        S_PERM: begin
          if (t_q == n_q) begin
            t_q <= '0;
            n_hot_q <= (hot_div == '0 && n_q != '0) ? NW'(1) : NW'(hot_div);
            n_warm_q <= NW'(warm_div);
            state_q <= S_ZONE;
          end else if (rank_q[t_q[SW-1:0]] == t_q[SW-1:0]) begin
            t_q <= t_q + 1'b1;
          end else if (out_free) begin
            logic [SW-1:0] a, b;
            a = t_q[SW-1:0];
            b = rank_q[a];
            for (int j = 0; j < SLOTS; j++)
              if (NW'(j) > t_q && NW'(j) < n_q && rank_q[j] == a) rank_q[j] <= b;
            rank_q[a] <= a;
            used_q[a] <= used_q[b]; used_q[b] <= used_q[a];
            zone_q[a] <= zone_q[b]; zone_q[b] <= zone_q[a];
            hits_q[a] <= hits_q[b]; hits_q[b] <= hits_q[a];
            owner_q[a] <= owner_q[b]; owner_q[b] <= owner_q[a];
            for (int j = 0; j < SLOTS; j++)
              if (NW'(j) < free_depth_q) begin
                if (free_q[j] == a) free_q[j] <= b;
                else if (free_q[j] == b) free_q[j] <= a;
              end
            if (slot_q == a) slot_q <= b;
            else if (slot_q == b) slot_q <= a;
            pa_q <= a;
            pb_q <= b;
            rsp.kind = KIND_SWAP;
            rsp.slot = 5'(a);
            rsp.partner_slot = 5'(b);
            emit = 1'b1;
            state_q <= S_PATCH;
          end
        end
        // patch the handle table for the first swapped slot, second below
        S_PATCH: begin
          state_q <= S_OUT;
        end
        S_OUT: begin
          t_q <= t_q + 1'b1;
          state_q <= S_PERM;
        end
        // zone the ranks, then clear the hit counters
        S_ZONE: begin
          if (t_q == n_q) begin
            for (int j = 0; j < SLOTS; j++) if (used_q[j]) hits_q[j] <= '0;
            state_q <= S_FIN;
          end else begin
            zone_q[t_q[SW-1:0]] <= (t_q < n_hot_q) ? TIER_HOT :
                                   (t_q < n_warm_q) ? TIER_WARM : TIER_COLD;
            t_q <= t_q + 1'b1;
          end
        end
        S_FIN: if (out_free) begin
          rsp.last = 1'b1;
          rsp.handle_out = req_q.handle_in;
          rsp.slot = 5'(slot_q);
          rsp.zone = zone_q[slot_q];
          emit = 1'b1;
          state_q <= S_IDLE;
        end
        default: state_q <= S_IDLE;
      endcase
      // result register
      if (emit) begin
        out_q <= rsp;
        out_valid_q <= 1'b1;
      end else if (out_valid_q && !out_stall_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // handle table writes: clearing, allocate, release, swap patches
  always_comb begin
    hm_we = 1'b0;
    hm_waddr = req_q.handle_in[HW-1:0];
    hm_wdata = '0;
    case (state_q)
      S_CLEAR: begin
        hm_we = 1'b1;
        hm_waddr = clr_q[HW-1:0];
      end
      S_EXEC: begin
        if (out_free && req_q.operation == OP_ALLOC && free_depth_q != '0 &&
            next_handle_q != HCW'(HANDLES)) begin
          hm_we = 1'b1;
          hm_waddr = next_handle_q[HW-1:0];
          hm_wdata = {1'b1, free_q[free_depth_q[SW-1:0] - 1'b1]};
        end else if (out_free && req_q.operation == OP_RELEASE &&
                     HCW'(req_q.handle_in) < next_handle_q && hm_rdata[SW]) begin
          hm_we = 1'b1;
        end
      end
      S_PATCH: begin
        hm_we = used_q[pa_q];
        hm_waddr = owner_q[pa_q];
        hm_wdata = {1'b1, pa_q};
      end
      S_OUT: begin
        hm_we = used_q[pb_q];
        hm_waddr = owner_q[pb_q];
        hm_wdata = {1'b1, pb_q};
      end
      default: ;
    endcase
  end

endmodule

>>> tb/sv/hot_cold_slot_allocator_test.sv
// testbench of the hot/cold slot allocator: predicted results checked against the block
module hot_cold_slot_allocator_test;
  timeunit 1ns;
  timeprecision 1ps;
  import hcsa_pkg::*;

  localparam int NSLOT = 32;
  localparam int NHANDLE = 1024;
  localparam int CYCLE_LIMIT = 900000;
  localparam int COMPACT_WAIT = 1300;

  logic clk_i = 1'b0;
  logic rst_ni = 1'b0;
  logic in_valid_i = 1'b0;
  logic in_stall_o;
  req_t in_data_i = '0;
  logic out_valid_o;
  logic out_stall_i = 1'b0;
  rsp_t out_data_o;
  logic cfg_we_i = 1'b0;
  logic cfg_index_i = 1'b0;
  logic [15:0] cfg_data_i = '0;

  hot_cold_slot_allocator u_top (
    .clk_i(clk_i), .rst_ni(rst_ni),
    .in_valid_i(in_valid_i), .in_stall_o(in_stall_o), .in_data_i(in_data_i),
    .out_valid_o(out_valid_o), .out_stall_i(out_stall_i), .out_data_o(out_data_o),
    .cfg_we_i(cfg_we_i), .cfg_index_i(cfg_index_i), .cfg_data_i(cfg_data_i)
  );

  always #4 clk_i = ~clk_i;

  // allocator state mirror
  logic [15:0] epoch_len;
  logic [6:0]  hot_pct;
  bit          map_ok [NHANDLE];
  logic [4:0]  map_slot [NHANDLE];
  bit          own_ok [NSLOT];
  int          owner [NSLOT];
  bit          busy [NSLOT];
  logic [1:0]  zone_of [NSLOT];
  int          hits [NSLOT];
  logic [4:0]  spare_slots [NSLOT];
  int          free_cnt;
  int          next_hdl;
  int          epoch_cnt;
  int          rank [NSLOT];

  rsp_t expected_q[$];
  int   live_handles[$];
  int   mismatches = 0;
  bit   failed = 1'b0;
  bit   idle_on = 1'b1;
  bit   long_hold = 1'b0;
  int   cycles = 0;

  function automatic rsp_t mk(logic k, logic [1:0] st, int h, int s, int p, logic [1:0] z,
                              logic l);
    rsp_t r;
    r.kind = k; r.status = st; r.handle_out = h[9:0]; r.slot = s[4:0];
    r.partner_slot = p[4:0]; r.zone = z; r.last = l;
    return r;
  endfunction

  function automatic void reset_mirror();
    epoch_len = 16'd1024; hot_pct = 7'd20;
    for (int i = 0; i < NHANDLE; i++) begin map_ok[i] = 0; map_slot[i] = '0; end
    for (int i = 0; i < NSLOT; i++) begin
      own_ok[i] = 0; owner[i] = 0; busy[i] = 0; zone_of[i] = TIER_COLD; hits[i] = 0;
      spare_slots[i] = 5'(NSLOT - 1 - i);
    end
    free_cnt = NSLOT; next_hdl = 0; epoch_cnt = 0;
  endfunction

  function automatic void exchange_slots(int a, int b);
    bit tb; logic [1:0] tz; int ti;
    if (a == b) return;
    tb = busy[a]; busy[a] = busy[b]; busy[b] = tb;
    tz = zone_of[a]; zone_of[a] = zone_of[b]; zone_of[b] = tz;
    ti = hits[a]; hits[a] = hits[b]; hits[b] = ti;
    tb = own_ok[a]; own_ok[a] = own_ok[b]; own_ok[b] = tb;
    ti = owner[a]; owner[a] = owner[b]; owner[b] = ti;
    if (own_ok[a]) map_slot[owner[a]] = 5'(a);
    if (own_ok[b]) map_slot[owner[b]] = 5'(b);
    for (int i = 0; i < free_cnt; i++) begin
      if (spare_slots[i] == a) spare_slots[i] = 5'(b);
      else if (spare_slots[i] == b) spare_slots[i] = 5'(a);
    end
  endfunction

  // rank used slots by hits, emit swaps, rezone
  function automatic void compact_slots();
    int n, j, cur, n_hot, n_warm;
    n = 0;
    for (int s = 0; s < NSLOT; s++) begin
      if (!busy[s]) continue;
      j = n;
      while (j > 0 && hits[rank[j-1]] < hits[s]) begin rank[j] = rank[j-1]; j--; end
      rank[j] = s; n++;
    end
    for (int t = 0; t < n; t++) begin
      cur = rank[t];
      if (cur == t) continue;
      for (j = t + 1; j < n; j++)
        if (rank[j] == t) begin rank[j] = cur; break; end
      exchange_slots(t, cur);
      rank[t] = t;
      expected_q.push_back(mk(KIND_SWAP, ST_OK, 0, t, cur, TIER_COLD, 1'b0));
    end
    n_hot = (n * int'(hot_pct)) / 100;
    if (n_hot < 1 && n > 0) n_hot = 1;
    n_warm = (n * (int'(hot_pct) + WarmExtra)) / 100;
    for (int t = 0; t < n; t++)
      zone_of[t] = t < n_hot ? TIER_HOT : (t < n_warm ? TIER_WARM : TIER_COLD);
    for (int s = 0; s < NSLOT; s++) if (busy[s]) hits[s] = 0;
  endfunction

  function automatic void predict_request(req_t q);
    int h, s;
    h = q.handle_in;
    if (q.operation == OP_ALLOC) begin
      if (free_cnt == 0) begin
        expected_q.push_back(mk(KIND_ANSWER, ST_NO_SLOT, 0, 0, 0, TIER_COLD, 1'b1)); return;
      end
      if (next_hdl >= NHANDLE) begin
        expected_q.push_back(mk(KIND_ANSWER, ST_EXHAUSTED, 0, 0, 0, TIER_COLD, 1'b1)); return;
      end
      free_cnt--;
      s = spare_slots[free_cnt];
      h = next_hdl++;
      map_ok[h] = 1; map_slot[h] = 5'(s); own_ok[s] = 1; owner[s] = h;
      busy[s] = 1; zone_of[s] = TIER_COLD; hits[s] = 0;
      live_handles.push_back(h);
      expected_q.push_back(mk(KIND_ANSWER, ST_OK, h, s, 0, TIER_COLD, 1'b1));
      return;
    end
    if (q.operation != OP_RELEASE && q.operation != OP_ACCESS || h >= next_hdl || !map_ok[h])
    begin
      expected_q.push_back(mk(KIND_ANSWER, ST_BAD, h, 0, 0, TIER_COLD, 1'b1)); return;
    end
    s = map_slot[h];
    if (q.operation == OP_RELEASE) begin
      map_ok[h] = 0; own_ok[s] = 0; owner[s] = 0; busy[s] = 0;
      spare_slots[free_cnt++] = 5'(s);
      foreach (live_handles[i]) if (live_handles[i] == h) begin
        live_handles.delete(i); break;
      end
      expected_q.push_back(mk(KIND_ANSWER, ST_OK, h, s, 0, zone_of[s], 1'b1));
      return;
    end
    if (hits[s] < 65535) hits[s]++;
    epoch_cnt = (epoch_cnt + 1) & 16'hFFFF;
    if (epoch_cnt >= epoch_len) begin
      epoch_cnt = 0;
      compact_slots();
      s = map_slot[h];
    end
    expected_q.push_back(mk(KIND_ANSWER, ST_OK, h, s, 0, zone_of[s], 1'b1));
  endfunction

  // result checker
  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (expected_q.size() == 0) begin
        failed = 1'b1; mismatches++;
        if (mismatches <= 10) $display("unexpected result %p", out_data_o);
      end else begin
        want = expected_q.pop_front();
        if (out_data_o !== want) begin
          failed = 1'b1; mismatches++;
          if (mismatches <= 10) $display("mismatch: expected %p actual %p", want, out_data_o);
        end
      end
    end
  end

  // receiver stall: random bursts, or a long hold
  always @(posedge clk_i) begin
    int hold;
    if (long_hold) begin
      out_stall_i <= 1'b1;
      for (hold = 0; hold < 300; hold++) @(posedge clk_i);
      long_hold = 1'b0;
      out_stall_i <= 1'b0;
    end else if (idle_on && $urandom_range(0, 7) == 0) begin
      out_stall_i <= 1'b1;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
      out_stall_i <= 1'b0;
    end
  end

  // cycle limit
  always @(posedge clk_i) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("== FAIL ==");
      $finish;
    end
  end

  // valid stays high after acceptance when the next request follows at once
  task automatic send_request(logic [1:0] op, int h);
    req_t q;
    q.operation = op; q.handle_in = h[9:0];
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk_i);
    end
    in_valid_i <= 1'b1;
    in_data_i <= q;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
    predict_request(q);
  endtask

  task automatic drain();
    in_valid_i <= 1'b0;
    while (expected_q.size() != 0) @(posedge clk_i);
    repeat (COMPACT_WAIT) @(posedge clk_i);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    cfg_we_i <= 1'b1; cfg_index_i <= idx; cfg_data_i <= val;
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    if (idx == REG_EPOCH_LENGTH) epoch_len = val;
    else hot_pct = val[6:0];
  endtask

  function automatic int pick_handle();
    if (live_handles.size() == 0 || $urandom_range(0, 9) == 0) return $urandom_range(0, 1023);
    return live_handles[$urandom_range(0, live_handles.size() - 1)];
  endfunction

  // directed: six allocates, bad handles, unknown code, double release, accesses across epochs
  task automatic test_directed();
    write_reg(REG_EPOCH_LENGTH, 16'd4);
    write_reg(REG_HOT_PERCENT, 7'd0);
    for (int i = 0; i < 6; i++) send_request(OP_ALLOC, 1023);
    send_request(OP_RELEASE, 1023);
    send_request(OP_ACCESS, 700);
    send_request(OP_INVALID, 5);
    send_request(OP_RELEASE, 2);
    send_request(OP_RELEASE, 2);
    send_request(OP_ACCESS, 2);
    for (int i = 0; i < 4; i++) send_request(OP_ACCESS, 5 - (i % 2));
    send_request(OP_ALLOC, 0);
    send_request(OP_ACCESS, 0);
    drain();
  endtask

  // epoch boundaries with extreme percentages
  task automatic test_epochs();
    write_reg(REG_HOT_PERCENT, 7'd127);
    write_reg(REG_EPOCH_LENGTH, 16'd1);
    for (int i = 0; i < 8; i++) send_request(OP_ACCESS, pick_handle());
    drain();
    write_reg(REG_HOT_PERCENT, 7'd100);
    write_reg(REG_EPOCH_LENGTH, 16'd0);
    for (int i = 0; i < 4; i++) send_request(OP_ACCESS, pick_handle());
    drain();
    write_reg(REG_EPOCH_LENGTH, 16'hFFFF);
    write_reg(REG_HOT_PERCENT, 7'd20);
    for (int i = 0; i < 4; i++) send_request(OP_ACCESS, pick_handle());
    drain();
  endtask

  // random mix, mostly valid handles
  task automatic test_random(int count);
    int r;
    for (int i = 0; i < count; i++) begin
      r = $urandom_range(0, 99);
      if (r < 30) send_request(OP_ALLOC, $urandom_range(0, 1023));
      else if (r < 45) send_request(OP_RELEASE, pick_handle());
      else if (r < 97) send_request(OP_ACCESS, pick_handle());
      else send_request(OP_INVALID, $urandom_range(0, 1023));
    end
  endtask

  // long receiver hold while requests keep coming, then sender pause
  task automatic test_backpressure();
    write_reg(REG_EPOCH_LENGTH, 16'd7);
    write_reg(REG_HOT_PERCENT, 7'd50);
    long_hold = 1'b1;
    test_random(30);
    drain();
  endtask

  // fill the pool to the brim with no idling, then one allocate too many
  task automatic test_fill_pool();
    write_reg(REG_EPOCH_LENGTH, 16'd3);
    write_reg(REG_HOT_PERCENT, 7'd35);
    idle_on = 1'b0;
    while (free_cnt > 0) send_request(OP_ALLOC, 0);
    send_request(OP_ALLOC, 0);
    test_random(10);
    drain();
  endtask

  initial begin
    reset_mirror();
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_epochs();
    write_reg(REG_EPOCH_LENGTH, 16'd5);
    write_reg(REG_HOT_PERCENT, 7'd10);
    test_random(30);
    drain();
    test_backpressure();
    test_fill_pool();
    if (!failed) begin
      $display("== PASS ==");
    end else begin
      $display("== FAIL ==");
    end
    $finish;
  end

endmodule

>>> hot_cold_slot_allocator.f
hw/rtl/hcsa_pkg.sv
hw/rtl/hcsa_ram.sv
hw/rtl/hot_cold_slot_allocator.sv
tb/sv/hot_cold_slot_allocator_test.sv
